// ===== rtl/irdfe_pkg.sv =====
// ----------------------------------------------------------------------------
// irdfe_pkg
// Shared types, register map, pair codes and the sequencer program for the
// infrared dibit frame encoder.
// ----------------------------------------------------------------------------
package irdfe_pkg;

  // fixed field widths
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned TICKS_W = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned FLAGS_W = 4;
  localparam int unsigned PAIR_W  = 34;

  // configuration port
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 6;
  localparam int unsigned REG_IDX_W  = 3;

  // register indexes (byte address is 8 * index)
  localparam logic [REG_IDX_W-1:0] REG_BIT_COUNT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_FLAGS = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_PAIR  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_DIBIT  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ONE_DIBIT   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_STOP_PAIR   = 3'd5;

  localparam logic [COUNT_W-1:0] BIT_COUNT_RESET = 6'd8;

  // frame_flags bit positions
  localparam int unsigned FLAG_MSB_FIRST = 0;
  localparam int unsigned FLAG_NEG_LOGIC = 1;
  localparam int unsigned FLAG_START_EN  = 2;
  localparam int unsigned FLAG_STOP_EN   = 3;

  // pair kinds, also used as the pair source select
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;

  // sequencer steps
  localparam int unsigned STEP_W = 2;
  localparam logic [STEP_W-1:0] STEP_IDLE  = 2'd0;
  localparam logic [STEP_W-1:0] STEP_START = 2'd1;
  localparam logic [STEP_W-1:0] STEP_DATA  = 2'd2;
  localparam logic [STEP_W-1:0] STEP_STOP  = 2'd3;

  // step conditions
  localparam int unsigned COND_W = 2;
  localparam logic [COND_W-1:0] COND_IN_REQ    = 2'd0;
  localparam logic [COND_W-1:0] COND_START_EN  = 2'd1;
  localparam logic [COND_W-1:0] COND_BITS_LEFT = 2'd2;
  localparam logic [COND_W-1:0] COND_STOP_EN   = 2'd3;

  // one control word of the sequencer program
  typedef struct packed {
    logic [COND_W-1:0] cond;      // what the step waits on or tests
    logic [KIND_W-1:0] kind;      // which pair is sent when the step hits
    logic              cnt_inc;   // advance the bit counter on a hit
    logic [STEP_W-1:0] next_hit;  // step after a request or a sent pair
    logic [STEP_W-1:0] next_miss; // step when the condition is false
  } ctrl_word_t;

  // sequencer program
  function automatic ctrl_word_t uc_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    unique case (step)
      STEP_IDLE:  w = '{COND_IN_REQ,    KIND_START, 1'b0, STEP_START, STEP_IDLE};
      STEP_START: w = '{COND_START_EN,  KIND_START, 1'b0, STEP_DATA,  STEP_DATA};
      STEP_DATA:  w = '{COND_BITS_LEFT, KIND_DATA,  1'b1, STEP_DATA,  STEP_STOP};
      STEP_STOP:  w = '{COND_STOP_EN,   KIND_STOP,  1'b0, STEP_IDLE,  STEP_IDLE};
      default:    w = '{COND_IN_REQ,    KIND_START, 1'b0, STEP_IDLE,  STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/irdfe_in_if.sv =====
// ----------------------------------------------------------------------------
// irdfe_in_if
// Input channel: one data word per request.
// ----------------------------------------------------------------------------
interface irdfe_in_if import irdfe_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);

endinterface

// ===== rtl/irdfe_out_if.sv =====
// ----------------------------------------------------------------------------
// irdfe_out_if
// Result channel: one segment pair per request.
// ----------------------------------------------------------------------------
interface irdfe_out_if import irdfe_pkg::*; ();

  logic               valid;
  logic               ready;
  logic               first_level;
  logic [TICKS_W-1:0] first_ticks;
  logic               second_level;
  logic [TICKS_W-1:0] second_ticks;
  logic [KIND_W-1:0]  pair_kind;
  logic               last;

  modport source (output valid, output first_level, output first_ticks,
                  output second_level, output second_ticks, output pair_kind,
                  output last, input ready);
  modport sink   (input valid, input first_level, input first_ticks,
                  input second_level, input second_ticks, input pair_kind,
                  input last, output ready);

endinterface

// ===== rtl/ir_dibit_frame_encoder_top.sv =====
// ----------------------------------------------------------------------------
// ir_dibit_frame_encoder_top
// Infrared frame encoder: one data word in, a run of segment pairs out
// (optional start pair, one dibit per data bit, optional stop pair).
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  in_ch     in         valid / ready      value[31:0]
//  out_ch    out        valid / ready      first_level, first_ticks[15:0],
//                                          second_level, second_ticks[15:0],
//                                          pair_kind[1:0], last
//  apb       in         psel/penable/pwrite paddr[5:0], pwdata[63:0], prdata
//
//  a four-step microcoded sequencer sends at most one pair per cycle, none while
//  the result register is held by out_ch.ready; a frame runs the idle step, the
//  start test, one data pair per bit plus the final bit test, then the stop step
//  before the sequencer returns to idle.
//  the result register lets the last pair wait while the next word is taken.
//  reset is synchronous; it returns the sequencer to idle and the registers to
//  their reset values (bit_count 8, all others 0). no clearing pass.
//
module ir_dibit_frame_encoder_top import irdfe_pkg::*; #(
  parameter int unsigned DATA_BITS = 32,
  parameter int unsigned TICK_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  irdfe_in_if.sink              in_ch,
  irdfe_out_if.source           out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned TICK_MASK_I = (1 << TICK_BITS) - 1;
  localparam logic [TICKS_W-1:0] TICK_MASK = TICKS_W'(TICK_MASK_I);
  localparam logic [COUNT_W-1:0] MAX_BITS  = COUNT_W'(DATA_BITS);

  // configuration registers
  logic [COUNT_W-1:0] bit_count_r;
  logic [FLAGS_W-1:0] frame_flags_r;
  logic [PAIR_W-1:0]  start_pair_r;
  logic [PAIR_W-1:0]  zero_dibit_r;
  logic [PAIR_W-1:0]  one_dibit_r;
  logic [PAIR_W-1:0]  stop_pair_r;

  // sequencer and datapath state
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [VALUE_W-1:0] value_r;

  // result register
  logic               out_valid_r;
  logic               first_level_r, second_level_r, last_r;
  logic [TICKS_W-1:0] first_ticks_r, second_ticks_r;
  logic [KIND_W-1:0]  pair_kind_r;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  ctrl_word_t           cw;
  logic                 cond_true, in_acc, slot_free, emit;
  logic [COUNT_W-1:0]   n_bits, pos;
  logic                 msb_first, inv, start_en, stop_en;
  logic                 data_bit, pair_last;
  logic [PAIR_W-1:0]    pair_sel;

  assign reg_idx = paddr[CFG_ADDR_W-1 -: REG_IDX_W];
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r   <= BIT_COUNT_RESET;
      frame_flags_r <= '0;
      start_pair_r  <= '0;
      zero_dibit_r  <= '0;
      one_dibit_r   <= '0;
      stop_pair_r   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BIT_COUNT:   bit_count_r   <= pwdata[COUNT_W-1:0];
        REG_FRAME_FLAGS: frame_flags_r <= pwdata[FLAGS_W-1:0];
        REG_START_PAIR:  start_pair_r  <= pwdata[PAIR_W-1:0];
        REG_ZERO_DIBIT:  zero_dibit_r  <= pwdata[PAIR_W-1:0];
        REG_ONE_DIBIT:   one_dibit_r   <= pwdata[PAIR_W-1:0];
        REG_STOP_PAIR:   stop_pair_r   <= pwdata[PAIR_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_BIT_COUNT:   prdata = CFG_DATA_W'(bit_count_r);
      REG_FRAME_FLAGS: prdata = CFG_DATA_W'(frame_flags_r);
      REG_START_PAIR:  prdata = CFG_DATA_W'(start_pair_r);
      REG_ZERO_DIBIT:  prdata = CFG_DATA_W'(zero_dibit_r);
      REG_ONE_DIBIT:   prdata = CFG_DATA_W'(one_dibit_r);
      REG_STOP_PAIR:   prdata = CFG_DATA_W'(stop_pair_r);
      default:         prdata = '0;
    endcase
  end

  // frame settings
  assign msb_first = frame_flags_r[FLAG_MSB_FIRST];
  assign inv       = frame_flags_r[FLAG_NEG_LOGIC];
  assign start_en  = frame_flags_r[FLAG_START_EN];
  assign stop_en   = frame_flags_r[FLAG_STOP_EN];
  assign n_bits    = (bit_count_r > MAX_BITS) ? MAX_BITS : bit_count_r;

  // control word of the current step
  assign cw = uc_rom(step_r);

  // condition select
  always_comb begin
    unique case (cw.cond)
      COND_IN_REQ:    cond_true = in_ch.valid;
      COND_START_EN:  cond_true = start_en;
      COND_BITS_LEFT: cond_true = (count_r != n_bits);
      COND_STOP_EN:   cond_true = stop_en;
      default:        cond_true = 1'b0;
    endcase
  end

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (cw.cond == COND_IN_REQ);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign emit        = (cw.cond != COND_IN_REQ) && cond_true && slot_free;

  // data bit select
  assign pos      = msb_first ? (n_bits - count_r - COUNT_W'(1)) : count_r;
  assign data_bit = value_r[pos[$clog2(VALUE_W)-1:0]];

  // pair source select and last-pair test
  always_comb begin
    unique case (cw.kind)
      KIND_START: begin
        pair_sel  = start_pair_r;
        pair_last = (n_bits == '0) && !stop_en;
      end
      KIND_DATA: begin
        pair_sel  = data_bit ? one_dibit_r : zero_dibit_r;
        pair_last = ((count_r + COUNT_W'(1)) == n_bits) && !stop_en;
      end
      KIND_STOP: begin
        pair_sel  = stop_pair_r;
        pair_last = 1'b1;
      end
      default: begin
        pair_sel  = '0;
        pair_last = 1'b0;
      end
    endcase
  end

  // next step and bit counter
  always_comb begin
    step_nxt  = step_r;
    count_nxt = count_r;
    if (cw.cond == COND_IN_REQ) begin
      if (in_acc) begin
        step_nxt  = cw.next_hit;
        count_nxt = '0;
      end
    end else if (!cond_true) begin
      step_nxt = cw.next_miss;
    end else if (emit) begin
      step_nxt = cw.next_hit;
      if (cw.cnt_inc) begin
        count_nxt = count_r + COUNT_W'(1);
      end
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= STEP_IDLE;
      count_r <= '0;
      value_r <= '0;
    end else begin
      step_r  <= step_nxt;
      count_r <= count_nxt;
      if (in_acc) begin
        value_r <= in_ch.value;
      end
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      first_level_r  <= pair_sel[33] ^ inv;
      first_ticks_r  <= pair_sel[32:17] & TICK_MASK;
      second_level_r <= pair_sel[16] ^ inv;
      second_ticks_r <= pair_sel[15:0] & TICK_MASK;
      pair_kind_r    <= cw.kind;
      last_r         <= pair_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.first_level  = first_level_r;
  assign out_ch.first_ticks  = first_ticks_r;
  assign out_ch.second_level = second_level_r;
  assign out_ch.second_ticks = second_ticks_r;
  assign out_ch.pair_kind    = pair_kind_r;
  assign out_ch.last         = last_r;

endmodule

// ===== dv/ir_dibit_frame_encoder_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_dibit_frame_encoder_top_tb
// Self-checking bench for the infrared dibit frame encoder. A shadow copy of
// the frame settings predicts every segment pair of each frame; pairs are
// checked in order as they leave the block, with random gaps on the word
// requests and random stalls on the pair requests.
// ----------------------------------------------------------------------------
module ir_dibit_frame_encoder_top_tb import irdfe_pkg::*; ();

  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned TICK_BITS = 16;

  // addresses past the register map, writes there must be dropped
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int unsigned    MAX_WAIT      = 10;
  localparam int unsigned    SETTLE_CYCLES = 60;
  localparam int unsigned    RAND_PHASES   = 12;
  localparam int unsigned    WORDS_PER_SET = 27;
  localparam longint unsigned CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic               first_level;
    logic [TICKS_W-1:0] first_ticks;
    logic               second_level;
    logic [TICKS_W-1:0] second_ticks;
    logic [KIND_W-1:0]  pair_kind;
    logic               last;
  } seg_pair_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  irdfe_in_if  in_if ();
  irdfe_out_if out_if ();

  ir_dibit_frame_encoder_top #(
    .DATA_BITS (DATA_BITS),
    .TICK_BITS (TICK_BITS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the frame settings
  logic [COUNT_W-1:0] sh_bit_count;
  logic [FLAGS_W-1:0] sh_flags;
  logic [PAIR_W-1:0]  sh_start;
  logic [PAIR_W-1:0]  sh_zero;
  logic [PAIR_W-1:0]  sh_one;
  logic [PAIR_W-1:0]  sh_stop;

  seg_pair_t       pending_pairs[$];
  int unsigned     send_wait_max = MAX_WAIT;
  int unsigned     stall_max     = MAX_WAIT;
  int unsigned     stall_left    = 0;
  int unsigned     err_cnt       = 0;
  longint unsigned cycle_cnt     = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // split one packed descriptor into a segment pair
  function automatic seg_pair_t unpack_pair(input logic [PAIR_W-1:0] desc,
                                            input logic [KIND_W-1:0] kind,
                                            input logic inv, input logic is_last);
    seg_pair_t p;
    logic [TICKS_W-1:0] tmask;
    tmask          = TICKS_W'((32'd1 << TICK_BITS) - 1);
    p.first_level  = desc[33] ^ inv;
    p.first_ticks  = desc[32:17] & tmask;
    p.second_level = desc[16] ^ inv;
    p.second_ticks = desc[15:0] & tmask;
    p.pair_kind    = kind;
    p.last         = is_last;
    return p;
  endfunction

  // expected pairs of the frame for one data word
  function automatic void encode_frame(input logic [VALUE_W-1:0] word);
    int unsigned nbits;
    int unsigned total;
    int unsigned idx;
    int unsigned pos;
    logic        inv;
    nbits = 32'(sh_bit_count);
    if (nbits > DATA_BITS) nbits = DATA_BITS;
    inv   = sh_flags[FLAG_NEG_LOGIC];
    total = nbits + 32'(sh_flags[FLAG_START_EN]) + 32'(sh_flags[FLAG_STOP_EN]);
    idx   = 0;
    if (sh_flags[FLAG_START_EN]) begin
      pending_pairs.push_back(unpack_pair(sh_start, KIND_START, inv, idx + 1 == total));
      idx++;
    end
    for (int unsigned k = 0; k < nbits; k++) begin
      pos = sh_flags[FLAG_MSB_FIRST] ? nbits - 1 - k : k;
      pending_pairs.push_back(unpack_pair(word[pos] ? sh_one : sh_zero, KIND_DATA, inv,
                                          idx + 1 == total));
      idx++;
    end
    if (sh_flags[FLAG_STOP_EN]) begin
      pending_pairs.push_back(unpack_pair(sh_stop, KIND_STOP, inv, idx + 1 == total));
    end
  endfunction

  // register write as the block sees it, extra bits dropped
  function automatic void shadow_write(input logic [REG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_BIT_COUNT:   sh_bit_count = data[COUNT_W-1:0];
      REG_FRAME_FLAGS: sh_flags     = data[FLAGS_W-1:0];
      REG_START_PAIR:  sh_start     = data[PAIR_W-1:0];
      REG_ZERO_DIBIT:  sh_zero      = data[PAIR_W-1:0];
      REG_ONE_DIBIT:   sh_one       = data[PAIR_W-1:0];
      REG_STOP_PAIR:   sh_stop      = data[PAIR_W-1:0];
      default: ;
    endcase
  endfunction

  // frame_flags write data
  function automatic logic [CFG_DATA_W-1:0] mk_flags(input logic msb, input logic neg,
                                                     input logic start, input logic stop);
    logic [CFG_DATA_W-1:0] f;
    f                 = '0;
    f[FLAG_MSB_FIRST] = msb;
    f[FLAG_NEG_LOGIC] = neg;
    f[FLAG_START_EN]  = start;
    f[FLAG_STOP_EN]   = stop;
    return f;
  endfunction

  // result side: random stall after each accepted pair
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    out_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        stall_left = $urandom_range(0, stall_max);
        if (stall_left != 0) out_if.ready <= 1'b0;
      end else if (!out_if.ready) begin
        if (stall_left > 0) stall_left--;
        if (stall_left == 0) out_if.ready <= 1'b1;
      end
    end
  end

  // compare each pair with the oldest prediction
  always @(posedge clk) begin : check_pairs
    seg_pair_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_pairs.size() == 0) begin
        err_cnt++;
        $error("unexpected pair: kind %0d, last %0d", out_if.pair_kind, out_if.last);
      end else begin
        want = pending_pairs.pop_front();
        if (out_if.first_level !== want.first_level) begin
          err_cnt++;
          $error("first_level: expected %0d, got %0d", want.first_level,
                 out_if.first_level);
        end
        if (out_if.first_ticks !== want.first_ticks) begin
          err_cnt++;
          $error("first_ticks: expected %0d, got %0d", want.first_ticks,
                 out_if.first_ticks);
        end
        if (out_if.second_level !== want.second_level) begin
          err_cnt++;
          $error("second_level: expected %0d, got %0d", want.second_level,
                 out_if.second_level);
        end
        if (out_if.second_ticks !== want.second_ticks) begin
          err_cnt++;
          $error("second_ticks: expected %0d, got %0d", want.second_ticks,
                 out_if.second_ticks);
        end
        if (out_if.pair_kind !== want.pair_kind) begin
          err_cnt++;
          $error("pair_kind: expected %0d, got %0d", want.pair_kind, out_if.pair_kind);
        end
        if (out_if.last !== want.last) begin
          err_cnt++;
          $error("last: expected %0d, got %0d", want.last, out_if.last);
        end
      end
    end
  end

  // one word request, random gap first; valid stays up for a following word
  task automatic send_word(input logic [VALUE_W-1:0] word);
    int unsigned gap;
    gap = $urandom_range(0, send_wait_max);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= word;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    encode_frame(word);
  endtask

  // drop valid, wait for all pairs, then let a frame with no pairs finish
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup and access phases, then back to idle
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow_write(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] count,
                           input logic [CFG_DATA_W-1:0] flags,
                           input logic [CFG_DATA_W-1:0] start,
                           input logic [CFG_DATA_W-1:0] zero,
                           input logic [CFG_DATA_W-1:0] one,
                           input logic [CFG_DATA_W-1:0] stop);
    wait_idle();
    write_reg(REG_BIT_COUNT, count);
    write_reg(REG_FRAME_FLAGS, flags);
    write_reg(REG_START_PAIR, start);
    write_reg(REG_ZERO_DIBIT, zero);
    write_reg(REG_ONE_DIBIT, one);
    write_reg(REG_STOP_PAIR, stop);
  endtask

  // frames with the settings left by reset
  task automatic test_reset_defaults();
    send_word('0);
    send_word('1);
    send_word(32'h0000_00A5);
    wait_idle();
  endtask

  // full-width and shorter frames, mixed flag settings, extreme descriptors
  task automatic test_pair_extremes();
    set_frame(64'd32, mk_flags(1'b0, 1'b0, 1'b1, 1'b1), 64'h3_FFFF_FFFF, 64'h0_0000_0000,
              64'h2_0001_8001, 64'h1_5555_2AAA);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h8000_0001);
    set_frame(64'd32, mk_flags(1'b1, 1'b1, 1'b1, 1'b1), 64'h1_2345_6789, 64'h2_FFFE_0001,
              64'h0_0001_FFFF, 64'h3_FFFF_FFFF);
    send_word(32'h1234_5678);
    set_frame(64'd13, mk_flags(1'b1, 1'b0, 1'b0, 1'b0), 64'h0, 64'h0_AAAA_5555,
              64'h3_5555_AAAA, 64'h0);
    send_word(32'h0000_1ABC);
    set_frame(64'd7, mk_flags(1'b0, 1'b1, 1'b0, 1'b0), 64'h0, 64'h3_0000_0000,
              64'h0_0001_0000, 64'h0);
    send_word(32'h0000_0055);
    wait_idle();
  endtask

  // saturation, masked value bits, empty frames, wide writes, spare addresses
  task automatic test_special_cases();
    // counts above the data width saturate
    set_frame(64'd33, mk_flags(1'b1, 1'b0, 1'b0, 1'b1), 64'h0, 64'h0_1111_2222,
              64'h3_3333_4444, 64'h2_0000_0001);
    send_word(32'hC000_0003);
    set_frame(64'd63, mk_flags(1'b0, 1'b0, 1'b1, 1'b0), 64'h1_0000_FFFF, 64'h0_1111_2222,
              64'h3_3333_4444, 64'h0);
    send_word(32'hC000_0003);
    // bits above the count are ignored
    set_frame(64'd4, mk_flags(1'b0, 1'b0, 1'b0, 1'b0), 64'h0, 64'h0_0002_0001,
              64'h2_0004_0003, 64'h0);
    send_word(32'hFFFF_FFF0);
    send_word(32'h0000_000F);
    // no bits and no start or stop: nothing comes out
    set_frame(64'd0, mk_flags(1'b0, 1'b0, 1'b0, 1'b0), 64'h2_0001_0001, 64'h0, 64'h0,
              64'h3_0002_0002);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    send_word(32'h5A5A_A5A5);
    set_frame(64'd0, mk_flags(1'b0, 1'b0, 1'b1, 1'b0), 64'h2_0001_0001, 64'h0, 64'h0,
              64'h3_0002_0002);
    send_word(32'hFFFF_FFFF);
    set_frame(64'd0, mk_flags(1'b0, 1'b1, 1'b0, 1'b1), 64'h2_0001_0001, 64'h0, 64'h0,
              64'h3_0002_0002);
    send_word(32'hFFFF_FFFF);
    set_frame(64'd0, mk_flags(1'b1, 1'b0, 1'b1, 1'b1), 64'h2_0001_0001, 64'h0, 64'h0,
              64'h3_0002_0002);
    send_word(32'h0000_0001);
    // single bit frame
    set_frame(64'd1, mk_flags(1'b1, 1'b0, 1'b0, 1'b0), 64'h0, 64'h1_0003_0004,
              64'h2_0005_0006, 64'h0);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    // upper write data bits are dropped
    set_frame(64'hFFFF_FFFF_FFFF_FFC3, 64'hFFFF_FFFF_FFFF_FFF5, 64'hFFFF_FFFC_0000_0001,
              64'hAAAA_AAA8_0001_0002, 64'h5555_5557_0000_0003, 64'hFFFF_FFFC_0000_0000);
    send_word(32'hFFFF_FFF5);
    // writes past the register map change nothing
    wait_idle();
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    send_word(32'h0000_0005);
    wait_idle();
  endtask

  // random settings per phase, random words, gaps and stalls on or off
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] data;
    logic [VALUE_W-1:0]    word;
    int unsigned           pick;
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      send_wait_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
      stall_max     = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
      pick = $urandom_range(0, 7);
      data = {$urandom, $urandom};
      case (pick)
        0:       data[COUNT_W-1:0] = COUNT_W'($urandom_range(33, 63));
        1:       data[COUNT_W-1:0] = COUNT_W'(DATA_BITS);
        2:       data[COUNT_W-1:0] = '0;
        default: data[COUNT_W-1:0] = COUNT_W'($urandom_range(1, 16));
      endcase
      write_reg(REG_BIT_COUNT, data);
      write_reg(REG_FRAME_FLAGS, {$urandom, $urandom});
      write_reg(REG_START_PAIR, {$urandom, $urandom});
      write_reg(REG_ZERO_DIBIT, {$urandom, $urandom});
      write_reg(REG_ONE_DIBIT, {$urandom, $urandom});
      write_reg(REG_STOP_PAIR, {$urandom, $urandom});
      if ($urandom_range(0, 2) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, {$urandom, $urandom});
      end
      for (int unsigned w = 0; w < WORDS_PER_SET; w++) begin
        pick = $urandom_range(0, 15);
        case (pick)
          0:       word = '0;
          1:       word = '1;
          2:       word = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
          default: word = $urandom;
        endcase
        send_word(word);
      end
    end
    send_wait_max = MAX_WAIT;
    stall_max     = MAX_WAIT;
    wait_idle();
  endtask

  // main sequence
  initial begin
    sh_bit_count = BIT_COUNT_RESET;
    sh_flags     = '0;
    sh_start     = '0;
    sh_zero      = '0;
    sh_one       = '0;
    sh_stop      = '0;
    rst_n       <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.value <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_pair_extremes();
    test_special_cases();
    test_random_traffic();

    wait_idle();
    if (err_cnt == 0 && pending_pairs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/irdfe_pkg.sv
rtl/irdfe_in_if.sv
rtl/irdfe_out_if.sv
rtl/ir_dibit_frame_encoder_top.sv
dv/ir_dibit_frame_encoder_top_tb.sv
